// ----- hw/rtl/bthp_pkg.sv -----
// Shared definitions for the BER identifier and length header parser.
// Holds parse phase codes, status codes, default widths and the result control struct.
// No dependencies.
`default_nettype none

package bthp_pkg;

    // Default widths of the tag and length accumulators.
    localparam int TAG_WIDTH_DEFAULT    = 32;
    localparam int LENGTH_WIDTH_DEFAULT = 64;

    // Width and reset value of the maximum long-form length octet count.
    localparam int           MAX_OCT_WIDTH = 4;
    localparam logic [3:0]   MAX_OCT_RESET = 4'd8;

    // Parse phases.
    localparam logic [1:0] PH_ID     = 2'd0;
    localparam logic [1:0] PH_TAG    = 2'd1;
    localparam logic [1:0] PH_LEN    = 2'd2;
    localparam logic [1:0] PH_LENOCT = 2'd3;

    // Header status codes.
    localparam logic [1:0] ST_OK           = 2'd0;
    localparam logic [1:0] ST_RESERVED_LEN = 2'd1;
    localparam logic [1:0] ST_LEN_OVERSIZE = 2'd2;
    localparam logic [1:0] ST_TAG_OVERFLOW = 2'd3;

    // Control side of one decode step: whether a header completes and how.
    typedef struct packed {
        logic       emit;
        logic       indefinite;
        logic [1:0] status;
    } bthp_result_ctrl_t;

endpackage

`default_nettype wire

// ----- hw/rtl/bthp_step.sv -----
// Combinational decode of one header octet against the current parser state.
// Produces the next parser state and, when a header ends, the result values.
// Depends on bthp_pkg.
`default_nettype none

module bthp_step
    import bthp_pkg::*;
#(
    parameter int TAG_WIDTH    = TAG_WIDTH_DEFAULT,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
)
(
    input  wire logic [7:0]               byte_value,
    input  wire logic                     restart,
    input  wire logic [MAX_OCT_WIDTH-1:0] max_length_octets,
    input  wire logic [1:0]               phase,
    input  wire logic [TAG_WIDTH-1:0]     tag_acc,
    input  wire logic [LENGTH_WIDTH-1:0]  len_acc,
    input  wire logic [3:0]               octets_left,
    output logic [1:0]                    phase_next,
    output logic [1:0]                    class_next,
    output logic                          constructed_next,
    output logic                          class_load,
    output logic [TAG_WIDTH-1:0]          tag_next,
    output logic [LENGTH_WIDTH-1:0]       len_next,
    output logic [3:0]                    octets_left_next,
    output bthp_result_ctrl_t             ctrl,
    output logic [TAG_WIDTH-1:0]          res_tag,
    output logic [LENGTH_WIDTH-1:0]       res_len
);

    logic [1:0]              phase_eff;
    logic [LENGTH_WIDTH-1:0] len_shift;
    logic [3:0]              left_dec;

    // A restart request overrides the phase and begins a new header.
    assign phase_eff = restart ? PH_ID : phase;
    assign len_shift = {len_acc[LENGTH_WIDTH-9:0], byte_value};
    assign left_dec  = octets_left - 4'd1;

    // Next state and result for this octet.
    always_comb
    begin
        phase_next       = phase_eff;
        class_next       = byte_value[7:6];
        constructed_next = byte_value[5];
        class_load       = 1'b0;
        tag_next         = tag_acc;
        len_next         = len_acc;
        octets_left_next = octets_left;
        ctrl.emit        = 1'b0;
        ctrl.indefinite  = 1'b0;
        ctrl.status      = ST_OK;
        res_tag          = tag_acc;
        res_len          = '0;

        unique case (phase_eff)
            PH_TAG:
            begin
                if (tag_acc[TAG_WIDTH-1 -: 7] != '0)
                begin
                    // Another base-128 group would push bits out of the tag.
                    ctrl.emit   = 1'b1;
                    ctrl.status = ST_TAG_OVERFLOW;
                    res_tag     = '0;
                    phase_next  = PH_ID;
                end
                else
                begin
                    tag_next   = {tag_acc[TAG_WIDTH-8:0], byte_value[6:0]};
                    phase_next = byte_value[7] ? PH_TAG : PH_LEN;
                end
            end

            PH_LEN:
            begin
                if (!byte_value[7])
                begin
                    // Short form length.
                    ctrl.emit  = 1'b1;
                    res_len    = {{(LENGTH_WIDTH-8){1'b0}}, byte_value};
                    phase_next = PH_ID;
                end
                else if (byte_value == 8'h80)
                begin
                    ctrl.emit       = 1'b1;
                    ctrl.indefinite = 1'b1;
                    phase_next      = PH_ID;
                end
                else if (byte_value == 8'hFF)
                begin
                    ctrl.emit   = 1'b1;
                    ctrl.status = ST_RESERVED_LEN;
                    phase_next  = PH_ID;
                end
                else if (byte_value[6:0] > {3'b000, max_length_octets})
                begin
                    ctrl.emit   = 1'b1;
                    ctrl.status = ST_LEN_OVERSIZE;
                    phase_next  = PH_ID;
                end
                else
                begin
                    // Long form: the count fits in four bits once it passed the limit.
                    len_next         = '0;
                    octets_left_next = byte_value[3:0];
                    phase_next       = PH_LENOCT;
                end
            end

            PH_LENOCT:
            begin
                if (len_acc[LENGTH_WIDTH-1 -: 8] != '0)
                begin
                    ctrl.emit   = 1'b1;
                    ctrl.status = ST_LEN_OVERSIZE;
                    phase_next  = PH_ID;
                end
                else
                begin
                    len_next         = len_shift;
                    octets_left_next = left_dec;
                    if (left_dec == 4'd0)
                    begin
                        ctrl.emit  = 1'b1;
                        res_len    = len_shift;
                        phase_next = PH_ID;
                    end
                end
            end

            default:
            begin
                // First identifier octet: class, constructed bit and tag form.
                class_load       = 1'b1;
                len_next         = '0;
                octets_left_next = 4'd0;
                if (byte_value[4:0] == 5'h1F)
                begin
                    tag_next   = '0;
                    phase_next = PH_TAG;
                end
                else
                begin
                    tag_next   = {{(TAG_WIDTH-5){1'b0}}, byte_value[4:0]};
                    phase_next = PH_LEN;
                end
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- hw/rtl/ber_tag_length_header_parser_unit.sv -----
// Usage notes for the BER identifier and length header parser.
// The input channel takes one header octet per request (byte_value, restart) under
// in_valid / in_ready. A restart request makes its octet the first identifier octet.
// The output channel carries one decoded header per request (tag_class, constructed,
// tag_number, content_length, length_indefinite, status) under out_valid / out_ready.
// Octets that do not end a header produce no output request.
// Throughput is one octet per clock unless a finished header waits on a stalled receiver:
// an input register feeds a single decode step whose result lands in the output register,
// and the parser state registers feed back into that step. A header ending on an accepted
// octet is decoded from the input register into the output register for the receiver.
// The configuration port (cfg_wr_en, cfg_wr_data) sets the most long-form length octets;
// the user must write it only while the parser is idle, as the block does not enforce it.
// When the receiver stalls, a finished header waits in the output register; octets that
// end no header keep flowing, and in_ready drops only when a second header would end.
// Reset clears the phase to expect an identifier octet, empties both registers and sets
// the length octet limit to eight.
// Depends on bthp_pkg and bthp_step.
`default_nettype none

module ber_tag_length_header_parser_unit
    import bthp_pkg::*;
#(
    parameter int TAG_WIDTH    = TAG_WIDTH_DEFAULT,
    parameter int LENGTH_WIDTH = LENGTH_WIDTH_DEFAULT
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     cfg_wr_en,
    input  wire logic [MAX_OCT_WIDTH-1:0] cfg_wr_data,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic [7:0]               byte_value,
    input  wire logic                     restart,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [1:0]                    tag_class,
    output logic                          constructed,
    output logic [TAG_WIDTH-1:0]          tag_number,
    output logic [LENGTH_WIDTH-1:0]       content_length,
    output logic                          length_indefinite,
    output logic [1:0]                    status
);

    logic [MAX_OCT_WIDTH-1:0] max_oct_reg;
    logic                     in_valid_reg;
    logic [7:0]               byte_reg;
    logic                     restart_reg;
    logic [1:0]               phase_reg;
    logic [1:0]               class_reg;
    logic                     constructed_reg;
    logic [TAG_WIDTH-1:0]     tag_acc_reg;
    logic [LENGTH_WIDTH-1:0]  len_acc_reg;
    logic [3:0]               left_reg;
    logic                     out_valid_reg;
    logic [1:0]               out_class_reg;
    logic                     out_constructed_reg;
    logic [TAG_WIDTH-1:0]     out_tag_reg;
    logic [LENGTH_WIDTH-1:0]  out_len_reg;
    logic                     out_indef_reg;
    logic [1:0]               out_status_reg;

    logic [1:0]               phase_next;
    logic [1:0]               class_next;
    logic                     constructed_next;
    logic                     class_load;
    logic [TAG_WIDTH-1:0]     tag_next;
    logic [LENGTH_WIDTH-1:0]  len_next;
    logic [3:0]               left_next;
    bthp_result_ctrl_t        step_ctrl;
    logic [TAG_WIDTH-1:0]     res_tag;
    logic [LENGTH_WIDTH-1:0]  res_len;
    logic                     advance;

    // Decode of the registered octet.
    bthp_step #(
        .TAG_WIDTH    (TAG_WIDTH),
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_step (
        .byte_value        (byte_reg),
        .restart           (restart_reg),
        .max_length_octets (max_oct_reg),
        .phase             (phase_reg),
        .tag_acc           (tag_acc_reg),
        .len_acc           (len_acc_reg),
        .octets_left       (left_reg),
        .phase_next        (phase_next),
        .class_next        (class_next),
        .constructed_next  (constructed_next),
        .class_load        (class_load),
        .tag_next          (tag_next),
        .len_next          (len_next),
        .octets_left_next  (left_next),
        .ctrl              (step_ctrl),
        .res_tag           (res_tag),
        .res_len           (res_len)
    );

    // The held octet is consumed unless it ends a header while the output is full.
    assign advance  = in_valid_reg && (!step_ctrl.emit || !out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_oct_reg <= MAX_OCT_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_oct_reg <= cfg_wr_data;
        end
    end

    // Control state: input valid, parse phase and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            phase_reg     <= PH_ID;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                in_valid_reg <= in_valid;
            end
            if (advance)
            begin
                phase_reg <= phase_next;
            end
            if (advance && step_ctrl.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Input octet register.
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            byte_reg    <= byte_value;
            restart_reg <= restart;
        end
    end

    // Header accumulators; the identifier octet initializes them before any use.
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            tag_acc_reg <= tag_next;
            len_acc_reg <= len_next;
            left_reg    <= left_next;
            if (class_load)
            begin
                class_reg       <= class_next;
                constructed_reg <= constructed_next;
            end
        end
    end

    // Result register.
    always_ff @(posedge clk)
    begin
        if (advance && step_ctrl.emit)
        begin
            out_class_reg       <= class_reg;
            out_constructed_reg <= constructed_reg;
            out_tag_reg         <= res_tag;
            out_len_reg         <= res_len;
            out_indef_reg       <= step_ctrl.indefinite;
            out_status_reg      <= step_ctrl.status;
        end
    end

    assign out_valid         = out_valid_reg;
    assign tag_class         = out_class_reg;
    assign constructed       = out_constructed_reg;
    assign tag_number        = out_tag_reg;
    assign content_length    = out_len_reg;
    assign length_indefinite = out_indef_reg;
    assign status            = out_status_reg;

endmodule

`default_nettype wire
